[hdl/imi_pkg.sv]
// ----------------------------------------------------------------------------
// imi_pkg
// Shared types and constants of the index map inverter.
// ----------------------------------------------------------------------------
`default_nettype none

package imi_pkg;

  // Default bound on map size (input and output positions)
  localparam int unsigned MAX_SIZE_DEF = 64;

  // Size registers and counters
  localparam int unsigned SIZE_W = 7;
  localparam int unsigned CFG_IDX_W = 1;

  // Payload widths
  localparam int unsigned CMD_W = 2;
  localparam int unsigned ENTRY_W = 16;
  localparam int unsigned QIDX_W = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned VALUE_W = 6;

  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 16;

  // Number of table indices a query can reach (query_index is 6 bits)
  localparam int unsigned QUERY_SPAN = 64;
  // Exclusive bound on entries a load can carry past the size check (input_size <= 127)
  localparam int unsigned ENTRY_SPAN = 128;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_IDLE  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_RANGE      = 3'd1,
    ST_TOO_MANY   = 3'd2,
    ST_INCOMPLETE = 3'd3,
    ST_NO_INVERSE = 3'd4
  } status_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE   = 2'd0,
    KIND_TRUE   = 2'd1,
    KIND_PSEUDO = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_RANGE    = 2'd1,
    ERR_TOO_MANY = 2'd2
  } err_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_SIZE  = 1'b0,
    CFG_OUTPUT_SIZE = 1'b1
  } cfg_idx_e;

endpackage

`default_nettype wire

[hdl/imi_table.sv]
// ----------------------------------------------------------------------------
// imi_table
// Inverse table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module imi_table #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 6
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/index_map_inverter.sv]
// ----------------------------------------------------------------------------
// index_map_inverter
// Builds the inverse of a forward index map one entry at a time and answers
// inverse queries.
// ----------------------------------------------------------------------------
// Usage:
//   Set input_size (index 0) and output_size (index 1) on the config port
//   while the block is idle. Then stream commands on the s_axis side:
//   start (clears coverage, counts, error), load (next map entry), query
//   (inverse of query_index), idle. Every accepted command yields exactly
//   one result transfer on the m_axis side.
// Timing / throughput:
//   A result is valid in the cycle after its command transfer; one command
//   per cycle unless the result side stalls. The inverse table is a single
//   synchronous RAM: a load writes it in the cycle it is accepted, a query
//   reads it then, and the registered read data is in the result word next cycle.
// Backpressure:
//   A single result register decouples the sides. s_axis_tready is high when
//   that register is empty or being drained this cycle, so a stalled
//   receiver holds the result and the block stops taking commands.
// Reset:
//   Coverage bits, counts, error and sizes clear at once; the table RAM is
//   not cleared (it is only read once every input index has been written).
// ----------------------------------------------------------------------------
`default_nettype none

module index_map_inverter #(
  parameter int unsigned MAX_SIZE = imi_pkg::MAX_SIZE_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // config write port
  input  wire logic                           cfg_we_i,
  input  wire logic [imi_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [imi_pkg::SIZE_W-1:0]     cfg_data_i,
  // command stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: cmd[1:0], entry_value[17:2], query_index[23:18]
  input  wire logic [imi_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata: status[2:0], inverse_kind[4:3], inverse_value[10:5], zero[15:11]
  output logic      [imi_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

  // Table only needs the indices a query can reach; coverage needs every
  // index a load can pass the size check with.
  localparam int unsigned TBL_DEPTH =
    (MAX_SIZE < imi_pkg::QUERY_SPAN) ? MAX_SIZE : imi_pkg::QUERY_SPAN;
  localparam int unsigned COV_DEPTH =
    (MAX_SIZE < imi_pkg::ENTRY_SPAN) ? MAX_SIZE : imi_pkg::ENTRY_SPAN;
  localparam int unsigned TBL_AW = $clog2(TBL_DEPTH);
  localparam int unsigned COV_AW = $clog2(COV_DEPTH);
  localparam int unsigned SW     = imi_pkg::SIZE_W;

  // ---- command fields ----
  imi_pkg::cmd_e                cmd;
  logic [imi_pkg::ENTRY_W-1:0]  entry;
  logic [imi_pkg::QIDX_W-1:0]   qidx;

  assign cmd   = imi_pkg::cmd_e'(s_axis_tdata[1:0]);
  assign entry = s_axis_tdata[17:2];
  assign qidx  = s_axis_tdata[23:18];

  // ---- state ----
  logic [SW-1:0]        in_size_q, out_size_q;
  logic [COV_DEPTH-1:0] cov_q, cov_d;
  logic [SW-1:0]        cov_cnt_q, cov_cnt_d;
  logic [SW-1:0]        ld_cnt_q, ld_cnt_d;
  imi_pkg::err_e        err_q, err_d;

  // result register
  logic                 out_vld_q, out_vld_d;
  imi_pkg::status_e     status_q, status_d;
  imi_pkg::kind_e       kind_q, kind_d;
  logic                 rd_sel_q, rd_sel_d;

  logic                 in_fire;
  logic                 too_many, entry_bad, q_bad, complete;
  imi_pkg::kind_e       map_kind;
  logic                 tbl_we, tbl_re;
  logic [imi_pkg::VALUE_W-1:0] tbl_rdata;

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // ---- checks against current state ----
  assign too_many  = (32'(ld_cnt_q) >= 32'(out_size_q)) || (32'(ld_cnt_q) >= MAX_SIZE);
  assign entry_bad = (32'(entry) >= 32'(in_size_q)) || (32'(entry) >= MAX_SIZE);
  assign q_bad     = (32'(qidx) >= 32'(in_size_q)) || (32'(qidx) >= MAX_SIZE);
  assign complete  = (ld_cnt_q == out_size_q);

  always_comb begin
    if (!complete || (cov_cnt_q != in_size_q)) begin
      map_kind = imi_pkg::KIND_NONE;
    end else if (in_size_q == out_size_q) begin
      map_kind = imi_pkg::KIND_TRUE;
    end else begin
      map_kind = imi_pkg::KIND_PSEUDO;
    end
  end

  // ---- config ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_size_q  <= '0;
      out_size_q <= '0;
    end else if (cfg_we_i) begin
      case (imi_pkg::cfg_idx_e'(cfg_idx_i))
        imi_pkg::CFG_INPUT_SIZE:  in_size_q  <= cfg_data_i;
        imi_pkg::CFG_OUTPUT_SIZE: out_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- command processing ----
  always_comb begin
    cov_d     = cov_q;
    cov_cnt_d = cov_cnt_q;
    ld_cnt_d  = ld_cnt_q;
    err_d     = err_q;
    status_d  = imi_pkg::ST_OK;
    kind_d    = imi_pkg::KIND_NONE;
    rd_sel_d  = 1'b0;
    tbl_we    = 1'b0;
    tbl_re    = 1'b0;
    case (cmd)
      imi_pkg::CMD_START: begin
        cov_d     = '0;
        cov_cnt_d = '0;
        ld_cnt_d  = '0;
        err_d     = imi_pkg::ERR_NONE;
      end
      imi_pkg::CMD_LOAD: begin
        if (too_many) begin
          err_d    = imi_pkg::ERR_TOO_MANY;
          status_d = imi_pkg::ST_TOO_MANY;
        end else if (entry_bad) begin
          err_d    = imi_pkg::ERR_RANGE;
          ld_cnt_d = ld_cnt_q + 1'b1;
          status_d = imi_pkg::ST_RANGE;
        end else begin
          // entry is below COV_DEPTH here
          if (!cov_q[entry[COV_AW-1:0]]) begin
            cov_d[entry[COV_AW-1:0]] = 1'b1;
            cov_cnt_d = cov_cnt_q + 1'b1;
          end
          ld_cnt_d = ld_cnt_q + 1'b1;
          tbl_we   = in_fire && (32'(entry) < TBL_DEPTH);
        end
      end
      imi_pkg::CMD_QUERY: begin
        case (err_q)
          imi_pkg::ERR_RANGE:    status_d = imi_pkg::ST_RANGE;
          imi_pkg::ERR_TOO_MANY: status_d = imi_pkg::ST_TOO_MANY;
          default: begin
            if (!complete) begin
              status_d = imi_pkg::ST_INCOMPLETE;
            end else if (map_kind == imi_pkg::KIND_NONE) begin
              status_d = imi_pkg::ST_NO_INVERSE;
            end else if (q_bad) begin
              status_d = imi_pkg::ST_RANGE;
            end else begin
              kind_d   = map_kind;
              rd_sel_d = 1'b1;
              tbl_re   = in_fire;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  // result register handshake
  always_comb begin
    out_vld_d = out_vld_q;
    if (in_fire) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cov_q     <= '0;
      cov_cnt_q <= '0;
      ld_cnt_q  <= '0;
      err_q     <= imi_pkg::ERR_NONE;
      out_vld_q <= 1'b0;
      rd_sel_q  <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (in_fire) begin
        cov_q     <= cov_d;
        cov_cnt_q <= cov_cnt_d;
        ld_cnt_q  <= ld_cnt_d;
        err_q     <= err_d;
        rd_sel_q  <= rd_sel_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
      kind_q   <= kind_d;
    end
  end

  // ---- inverse table ----
  imi_table #(
    .DEPTH (TBL_DEPTH),
    .AW    (TBL_AW),
    .DW    (imi_pkg::VALUE_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (entry[TBL_AW-1:0]),
    .wdata_i (ld_cnt_q[imi_pkg::VALUE_W-1:0]),
    .re_i    (tbl_re),
    .raddr_i (qidx[TBL_AW-1:0]),
    .rdata_o (tbl_rdata)
  );

  // ---- result word ----
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {
    5'b0,
    (rd_sel_q ? tbl_rdata : {imi_pkg::VALUE_W{1'b0}}),
    kind_q,
    status_q
  };

endmodule

`default_nettype wire

[hdl/imi_checker.sv]
// ----------------------------------------------------------------------------
// imi_checker
// Port-level checks of the index map inverter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module imi_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic [imi_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [imi_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  // held result stays put while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // every command transfer shows its result in the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("no result after command transfer");

  // start answers all zero
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready
      && (s_axis_tdata[1:0] == imi_pkg::CMD_START) |=> m_axis_tdata == '0)
    else $error("start result not zero");

  // value and kind only accompany an ok status
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] != imi_pkg::ST_OK)
      |-> m_axis_tdata[10:3] == '0)
    else $error("error result carries kind or value");

endmodule

bind index_map_inverter imi_checker u_imi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
